### hw/rtl/srs_pkg.sv
// Shared constants, codes and types for the sequential random sampler.
package srs_pkg;

  localparam int COUNT_BITS  = 20;
  localparam int MAX_CLASSES = 16;
  localparam int MAX_BLOCK   = 64;
  localparam int CLASS_BITS  = 4;
  localparam int BLOCK_BITS  = 7;
  localparam int GEN_BITS    = 48;
  localparam int MUL_BITS    = 35;
  localparam int PROD_BITS   = GEN_BITS + MUL_BITS;
  localparam int STEP_BITS   = 6;

  localparam logic [MUL_BITS-1:0]   GEN_MUL    = 35'h5DEECE66D;
  localparam logic [GEN_BITS-1:0]   GEN_ADD    = 48'hB;
  localparam logic [15:0]           GEN_LOW    = 16'h330E;
  localparam logic [31:0]           SEED_RESET = 32'd2741;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};

  localparam logic [1:0] FUNC_RESTART = 2'd0;
  localparam logic [1:0] FUNC_TALLY   = 2'd1;
  localparam logic [1:0] FUNC_DRAW    = 2'd2;

  localparam logic [2:0] REG_SEED     = 3'd0;
  localparam logic [2:0] REG_TOTAL    = 3'd1;
  localparam logic [2:0] REG_CHOOSE   = 3'd2;
  localparam logic [2:0] REG_BLOCK    = 3'd3;
  localparam logic [2:0] REG_BALANCED = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GEN,
    ST_CMP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic start;
  } mul_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_sts_t;

endpackage

### hw/rtl/srs_smul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module srs_smul (
  input  logic                            clk,
  input  logic                            rst,
  input  srs_pkg::mul_ctl_t               ctl,
  input  logic [srs_pkg::GEN_BITS-1:0]    a,
  input  logic [srs_pkg::MUL_BITS-1:0]    b,
  output srs_pkg::mul_sts_t               sts,
  output logic [srs_pkg::PROD_BITS-1:0]   prod
);

  logic [srs_pkg::GEN_BITS-1:0]  a_r;
  logic [srs_pkg::PROD_BITS-1:0] p;
  logic [srs_pkg::STEP_BITS-1:0] cnt;
  logic                          busy;
  logic                          done;
  logic [srs_pkg::GEN_BITS:0]    sum;

  // add the multiplicand into the upper half when the low bit is set, then shift right
  assign sum = {1'b0, p[srs_pkg::PROD_BITS-1:srs_pkg::MUL_BITS]} +
               (p[0] ? {1'b0, a_r} : {(srs_pkg::GEN_BITS+1){1'b0}});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        a_r  <= a;
        p    <= {{srs_pkg::GEN_BITS{1'b0}}, b};
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        p   <= {sum, p[srs_pkg::MUL_BITS-1:1]};
        cnt <= cnt + 1'b1;
        if (cnt == srs_pkg::STEP_BITS'(srs_pkg::MUL_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
  assign prod     = p;

endmodule

### hw/rtl/sequential_random_sampler.sv
// Top level: selection sampler with a 48-bit congruential generator and APB registers.
// Restart and tally complete on acceptance; a draw runs a generator multiply and then a
// compare multiply on the one bit-serial multiplier (each a load plus one shift-add step per
// multiplier bit), then shows one copy per cycle while out_stall is low. The next
// transaction is taken in the cycle after the last copy leaves. Synchronous active-high
// rst restores register defaults, the generator seed value and zero counters.
module sequential_random_sampler (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      func,
  input  logic [srs_pkg::CLASS_BITS-1:0]  class_index,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            indicator,
  output logic                            last_copy,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [4:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam int CB = srs_pkg::COUNT_BITS;

  srs_pkg::state_t state, state_next;

  logic [31:0]                    seed_value;
  logic [CB-1:0]                  total_items;
  logic [CB-1:0]                  choose_count;
  logic [srs_pkg::BLOCK_BITS-1:0] block_size;
  logic                           balanced_mode;

  logic [srs_pkg::GEN_BITS-1:0]   gen;
  logic [CB-1:0]                  items_remaining;
  logic [CB-1:0]                  ones_wanted;
  logic [CB-1:0]                  class_remaining [srs_pkg::MAX_CLASSES];
  logic [CB-1:0]                  class_wanted    [srs_pkg::MAX_CLASSES];

  logic [CB-1:0]                  rem_w;
  logic [CB-1:0]                  want_w;
  logic [srs_pkg::CLASS_BITS-1:0] cls_r;
  logic                           bal_r;
  logic                           sel_r;
  logic [srs_pkg::BLOCK_BITS-1:0] copies_left;

  srs_pkg::mul_ctl_t              mul_ctl;
  srs_pkg::mul_sts_t              mul_sts;
  logic [srs_pkg::GEN_BITS-1:0]   mul_a;
  logic [srs_pkg::MUL_BITS-1:0]   mul_b;
  logic [srs_pkg::PROD_BITS-1:0]  prod;

  logic                           in_acc;
  logic                           out_acc;
  logic                           cfg_wr;
  logic [2:0]                     cfg_idx;
  logic                           cls_ok;
  logic [srs_pkg::GEN_BITS-1:0]   gen_new;
  logic                           sel;
  logic [CB-1:0]                  rem_dec;
  logic [CB-1:0]                  want_dec;
  logic [srs_pkg::BLOCK_BITS-1:0] copies;

  srs_smul u_smul (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mul_ctl),
    .a    (mul_a),
    .b    (mul_b),
    .sts  (mul_sts),
    .prod (prod)
  );

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];
  assign cls_ok  = 32'(class_index) < srs_pkg::MAX_CLASSES;
  assign gen_new = prod[srs_pkg::GEN_BITS-1:0] + srs_pkg::GEN_ADD;
  // x * rem < want * 2^48 holds exactly when the product's bits above 48 are below want
  assign sel     = (rem_w == '0) ||
                   (prod[srs_pkg::GEN_BITS+CB-1:srs_pkg::GEN_BITS] < want_w);
  assign rem_dec  = (rem_w != '0) ? rem_w - 1'b1 : rem_w;
  assign want_dec = (sel && want_w != '0) ? want_w - 1'b1 : want_w;

  always_comb begin
    priority if (block_size == '0)
      copies = srs_pkg::BLOCK_BITS'(1);
    else if (32'(block_size) > srs_pkg::MAX_BLOCK)
      copies = srs_pkg::BLOCK_BITS'(srs_pkg::MAX_BLOCK);
    else
      copies = block_size;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      srs_pkg::ST_IDLE:
        if (in_acc && func == srs_pkg::FUNC_DRAW && (!balanced_mode || cls_ok))
          state_next = srs_pkg::ST_GEN;
      srs_pkg::ST_GEN:
        if (mul_sts.done) state_next = srs_pkg::ST_CMP;
      srs_pkg::ST_CMP:
        if (mul_sts.done) state_next = srs_pkg::ST_EMIT;
      srs_pkg::ST_EMIT:
        if (out_acc && copies_left == srs_pkg::BLOCK_BITS'(1)) state_next = srs_pkg::ST_IDLE;
      default: state_next = srs_pkg::ST_IDLE;
    endcase
  end

  // outputs and multiplier control
  always_comb begin
    in_stall      = 1'b1;
    out_valid     = 1'b0;
    mul_ctl.start = 1'b0;
    mul_a         = gen;
    mul_b         = srs_pkg::GEN_MUL;
    unique case (state)
      srs_pkg::ST_IDLE: begin
        in_stall      = 1'b0;
        mul_ctl.start = in_valid && func == srs_pkg::FUNC_DRAW && (!balanced_mode || cls_ok);
      end
      srs_pkg::ST_GEN: begin
        // feed the stepped generator straight into the compare multiply
        mul_ctl.start = mul_sts.done;
        mul_a         = gen_new;
        mul_b         = srs_pkg::MUL_BITS'(rem_w);
      end
      srs_pkg::ST_CMP: begin
      end
      srs_pkg::ST_EMIT: begin
        out_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign indicator = sel_r;
  assign last_copy = (copies_left == srs_pkg::BLOCK_BITS'(1));
  assign pready    = 1'b1;

  always_comb begin
    unique case (cfg_idx)
      srs_pkg::REG_SEED:     prdata = seed_value;
      srs_pkg::REG_TOTAL:    prdata = 32'(total_items);
      srs_pkg::REG_CHOOSE:   prdata = 32'(choose_count);
      srs_pkg::REG_BLOCK:    prdata = 32'(block_size);
      srs_pkg::REG_BALANCED: prdata = 32'(balanced_mode);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= srs_pkg::ST_IDLE;
      seed_value      <= srs_pkg::SEED_RESET;
      total_items     <= CB'(1);
      choose_count    <= '0;
      block_size      <= srs_pkg::BLOCK_BITS'(1);
      balanced_mode   <= 1'b0;
      gen             <= {srs_pkg::SEED_RESET, srs_pkg::GEN_LOW};
      items_remaining <= '0;
      ones_wanted     <= '0;
      copies_left     <= '0;
      for (int i = 0; i < srs_pkg::MAX_CLASSES; i++) begin
        class_remaining[i] <= '0;
        class_wanted[i]    <= '0;
      end
    end else begin
      state <= state_next;

      if (cfg_wr) begin
        unique case (cfg_idx)
          srs_pkg::REG_SEED:     seed_value    <= pwdata;
          srs_pkg::REG_TOTAL:    total_items   <= pwdata[CB-1:0];
          srs_pkg::REG_CHOOSE:   choose_count  <= pwdata[CB-1:0];
          srs_pkg::REG_BLOCK:    block_size    <= pwdata[srs_pkg::BLOCK_BITS-1:0];
          srs_pkg::REG_BALANCED: balanced_mode <= pwdata[0];
          default: begin
          end
        endcase
      end

      if (state == srs_pkg::ST_IDLE && in_acc) begin
        unique case (func)
          srs_pkg::FUNC_RESTART: begin
            gen             <= {seed_value, srs_pkg::GEN_LOW};
            items_remaining <= total_items;
            ones_wanted     <= choose_count;
            for (int i = 0; i < srs_pkg::MAX_CLASSES; i++) begin
              class_remaining[i] <= '0;
              class_wanted[i]    <= choose_count;
            end
          end
          srs_pkg::FUNC_TALLY: begin
            if (cls_ok && class_remaining[class_index] != srs_pkg::COUNT_MAX)
              class_remaining[class_index] <= class_remaining[class_index] + 1'b1;
          end
          srs_pkg::FUNC_DRAW: begin
            cls_r <= class_index;
            bal_r <= balanced_mode;
            if (balanced_mode) begin
              rem_w       <= class_remaining[class_index];
              want_w      <= class_wanted[class_index];
              copies_left <= srs_pkg::BLOCK_BITS'(1);
            end else begin
              rem_w       <= items_remaining;
              want_w      <= ones_wanted;
              copies_left <= copies;
            end
          end
          default: begin
          end
        endcase
      end

      if (state == srs_pkg::ST_GEN && mul_sts.done) gen <= gen_new;

      if (state == srs_pkg::ST_CMP && mul_sts.done) begin
        sel_r <= sel;
        if (bal_r) begin
          class_remaining[cls_r] <= rem_dec;
          class_wanted[cls_r]    <= want_dec;
        end else begin
          items_remaining <= rem_dec;
          ones_wanted     <= want_dec;
        end
      end

      // advance through the copies of this run
      if (state == srs_pkg::ST_EMIT && out_acc) copies_left <= copies_left - 1'b1;
    end
  end

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    out_acc && last_copy |=> !out_valid)
    else $error("result run did not end after its last copy");

  a_mul_owned: assert property (@(posedge clk) disable iff (rst)
    mul_sts.done |-> (state == srs_pkg::ST_GEN || state == srs_pkg::ST_CMP))
    else $error("multiplier finished outside a draw");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    in_acc |-> !out_valid && !mul_sts.busy)
    else $error("transaction accepted while a draw is in progress");

  a_copies_live: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> copies_left != '0)
    else $error("result shown with no copies left");

endmodule

### tb/sv/tb_sequential_random_sampler.sv
// Self-checking testbench for the sequential random sampler: directed and random transactions.
module tb_sequential_random_sampler;
  timeunit 1ns;
  timeprecision 1ps;

  import srs_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 100;
  localparam int LONG_HOLD     = 400;
  localparam int STALL_LIMIT   = 3000;

  typedef struct {
    logic [1:0]            f;
    logic [CLASS_BITS-1:0] c;
  } item_t;

  typedef struct packed {
    logic ind;
    logic is_last;
  } copy_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            func = FUNC_RESTART;
  logic [CLASS_BITS-1:0] class_index = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  indicator;
  logic                  last_copy;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [4:0]            paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  sequential_random_sampler uut (
    .clk, .rst, .in_valid, .in_stall, .func, .class_index,
    .out_valid, .out_stall, .indicator, .last_copy,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register mirror
  logic [31:0]           cfg_seed = SEED_RESET;
  logic [COUNT_BITS-1:0] cfg_total = COUNT_BITS'(1);
  logic [COUNT_BITS-1:0] cfg_choose = '0;
  logic [BLOCK_BITS-1:0] cfg_block = BLOCK_BITS'(1);
  logic                  cfg_balanced = 1'b0;

  // sampler state
  logic [GEN_BITS-1:0]   gen_state = {SEED_RESET, GEN_LOW};
  logic [COUNT_BITS-1:0] plain_remaining = '0;
  logic [COUNT_BITS-1:0] plain_wanted = '0;
  logic [COUNT_BITS-1:0] cls_remaining [MAX_CLASSES] = '{default: '0};
  logic [COUNT_BITS-1:0] cls_wanted [MAX_CLASSES] = '{default: '0};

  item_t pending_items[$];
  copy_t expected_copies[$];
  int    error_count = 0;
  bit    gaps_on = 1'b1;
  int    hold_requests = 0;
  int    hold_seen = 0;
  int    hold_left = 0;
  int    quiet_cycles = 0;

  task automatic flag_error(input string what);
    error_count++;
    if (error_count <= 10) $display("%0t ns: %s", $realtime, what);
  endtask

  // Advance the sampler by one accepted transaction and queue the copies it yields.
  task automatic predict_transaction(input logic [1:0] f, input logic [CLASS_BITS-1:0] c);
    logic [COUNT_BITS-1:0] rem;
    logic [COUNT_BITS-1:0] want;
    logic                  sel;
    int                    copies;
    copy_t                 e;
    case (f)
      FUNC_RESTART: begin
        gen_state = {cfg_seed, GEN_LOW};
        plain_remaining = cfg_total;
        plain_wanted = cfg_choose;
        for (int i = 0; i < MAX_CLASSES; i++) begin
          cls_remaining[i] = '0;
          cls_wanted[i] = cfg_choose;
        end
      end
      FUNC_TALLY: begin
        if (cls_remaining[c] != COUNT_MAX) cls_remaining[c] = cls_remaining[c] + 1'b1;
      end
      FUNC_DRAW: begin
        if (cfg_balanced) begin
          rem = cls_remaining[c];
          want = cls_wanted[c];
        end else begin
          rem = plain_remaining;
          want = plain_wanted;
        end
        gen_state = gen_state * GEN_MUL + GEN_ADD;
        // exact form of uniform < wanted / remaining
        sel = (rem == 0) || ((128'(gen_state) * 128'(rem)) < (128'(want) << GEN_BITS));
        if (sel && want != 0) want = want - 1'b1;
        if (rem != 0) rem = rem - 1'b1;
        if (cfg_balanced) begin
          cls_remaining[c] = rem;
          cls_wanted[c] = want;
          copies = 1;
        end else begin
          plain_remaining = rem;
          plain_wanted = want;
          copies = (cfg_block == 0) ? 1 : (cfg_block > MAX_BLOCK) ? MAX_BLOCK : int'(cfg_block);
        end
        for (int i = 0; i < copies; i++) begin
          e.ind = sel;
          e.is_last = (i == copies - 1);
          expected_copies.insert(expected_copies.size(), e);
        end
      end
      default: ;
    endcase
  endtask

  // driver: hold the payload until accepted, then maybe idle
  always @(posedge clk) begin : driver
    item_t next_item;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_transaction(func, class_index);
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && !(gaps_on && $urandom_range(99) < 20)) begin
          next_item = pending_items.pop_front();
          in_valid <= 1'b1;
          func <= next_item.f;
          class_index <= next_item.c;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_requests) begin
      hold_seen <= hold_requests;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else begin
      out_stall <= gaps_on && ($urandom_range(99) < 20);
    end
  end

  always @(posedge clk) begin : monitor
    copy_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_copies.size() == 0) begin
        flag_error($sformatf("unexpected result indicator=%0b last_copy=%0b",
                             indicator, last_copy));
      end else begin
        want = expected_copies.pop_front();
        if (indicator !== want.ind || last_copy !== want.is_last)
          flag_error($sformatf("mismatch: expected indicator=%0b last_copy=%0b, got %0b %0b",
                               want.ind, want.is_last, indicator, last_copy));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SEED:     cfg_seed = val;
      REG_TOTAL:    cfg_total = val[COUNT_BITS-1:0];
      REG_CHOOSE:   cfg_choose = val[COUNT_BITS-1:0];
      REG_BLOCK:    cfg_block = val[BLOCK_BITS-1:0];
      REG_BALANCED: cfg_balanced = val[0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [31:0] seed, input logic [COUNT_BITS-1:0] total,
                           input logic [COUNT_BITS-1:0] choose,
                           input logic [BLOCK_BITS-1:0] blk, input logic bal);
    write_reg(REG_SEED, seed);
    write_reg(REG_TOTAL, 32'(total));
    write_reg(REG_CHOOSE, 32'(choose));
    write_reg(REG_BLOCK, 32'(blk));
    write_reg(REG_BALANCED, 32'(bal));
  endtask

  // Wait until every transaction is in and out, then let restarts and tallies drain.
  task automatic settle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_copies.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_item(input logic [1:0] f, input logic [CLASS_BITS-1:0] c);
    item_t it;
    it.f = f;
    it.c = c;
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic run_random_phase(input int n_items, input bit long_hold);
    logic [31:0]           seed;
    logic [COUNT_BITS-1:0] total;
    logic [COUNT_BITS-1:0] choose;
    logic [BLOCK_BITS-1:0] blk;
    logic                  bal;
    logic [CLASS_BITS-1:0] cls;
    int                    pick;
    bal = 1'($urandom_range(1));
    seed = $urandom;
    case ($urandom_range(3))
      0: total = COUNT_BITS'($urandom_range(8, 1));
      1: total = COUNT_BITS'($urandom_range(60, 1));
      2: total = COUNT_BITS'($urandom_range(COUNT_MAX, 1));
      default: total = COUNT_BITS'(1 + $urandom_range(20));
    endcase
    case ($urandom_range(3))
      0: choose = '0;
      1: choose = COUNT_BITS'($urandom_range(int'(total) + 2));
      2: choose = COUNT_BITS'($urandom_range(COUNT_MAX));
      default: choose = total;
    endcase
    pick = $urandom_range(99);
    blk = BLOCK_BITS'((pick < 70) ? $urandom_range(4, 1) :
                      (pick < 90) ? $urandom_range(MAX_BLOCK, 1) : MAX_BLOCK);
    if (long_hold) begin
      bal = 1'b0;
      blk = BLOCK_BITS'(4);
    end
    settle();
    configure(seed, total, choose, blk, bal);
    @(negedge clk);
    queue_item(FUNC_RESTART, CLASS_BITS'($urandom_range(15)));
    for (int i = 1; i < n_items; i++) begin
      pick = $urandom_range(99);
      cls = CLASS_BITS'(($urandom_range(1) != 0) ? $urandom_range(3) : $urandom_range(15));
      if (pick < 10) queue_item(2'($urandom_range(3)), CLASS_BITS'($urandom_range(15)));
      else if (bal && pick < 55) queue_item(FUNC_TALLY, cls);
      else queue_item(FUNC_DRAW, cls);
    end
    if (long_hold) hold_requests <= hold_requests + 1;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset values: zero remaining selects, then one item with nothing wanted
    @(negedge clk);
    queue_item(FUNC_DRAW, '0);
    queue_item(FUNC_UNUSED, CLASS_BITS'(5));
    queue_item(FUNC_RESTART, '0);
    queue_item(FUNC_DRAW, '0);
    queue_item(FUNC_DRAW, '0);

    settle();
    configure(32'hFFFF_FFFF, COUNT_MAX, COUNT_MAX, BLOCK_BITS'(MAX_BLOCK), 1'b0);
    @(negedge clk);
    queue_item(FUNC_RESTART, CLASS_BITS'(15));
    queue_item(FUNC_DRAW, CLASS_BITS'(15));
    queue_item(FUNC_DRAW, '0);

    // block size zero acts as one
    settle();
    configure(32'h0, COUNT_BITS'(1), COUNT_BITS'(1), '0, 1'b0);
    @(negedge clk);
    queue_item(FUNC_RESTART, '0);
    queue_item(FUNC_DRAW, '0);
    queue_item(FUNC_DRAW, '0);

    // block size beyond the maximum clamps
    settle();
    configure(32'h0000_1234, COUNT_BITS'(5), COUNT_BITS'(2), 7'd127, 1'b0);
    @(negedge clk);
    queue_item(FUNC_RESTART, '0);
    queue_item(FUNC_DRAW, '0);
    queue_item(FUNC_DRAW, '0);

    // balanced: wanted above remaining, empty classes, both class extremes
    settle();
    configure(32'hA5A5_5A5A, COUNT_BITS'(1), COUNT_BITS'(3), BLOCK_BITS'(1), 1'b1);
    @(negedge clk);
    queue_item(FUNC_RESTART, '0);
    queue_item(FUNC_TALLY, '0);
    queue_item(FUNC_TALLY, '0);
    queue_item(FUNC_TALLY, CLASS_BITS'(15));
    queue_item(FUNC_DRAW, '0);
    queue_item(FUNC_DRAW, '0);
    queue_item(FUNC_DRAW, '0);
    queue_item(FUNC_DRAW, CLASS_BITS'(15));
    queue_item(FUNC_DRAW, CLASS_BITS'(7));
    queue_item(FUNC_TALLY, CLASS_BITS'(9));
    queue_item(FUNC_DRAW, CLASS_BITS'(9));

    for (int p = 0; p < 7; p++) begin
      if (p == 3) begin
        settle();
        gaps_on <= 1'b0;
      end else if (p == 4) begin
        settle();
        gaps_on <= 1'b1;
      end
      run_random_phase(30, p == 1);
    end

    settle();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/srs_pkg.sv
hw/rtl/srs_smul.sv
hw/rtl/sequential_random_sampler.sv
tb/sv/tb_sequential_random_sampler.sv
